/* rtl/cpsm_pkg.sv */
// Shared types and constants for the capture period speed meter.
// No dependencies; every other file depends on this package.
package cpsm_pkg;

    localparam int CAP_W    = 16;
    localparam int PERIOD_W = 32;
    localparam int SPEED_W  = 24;
    localparam int CLASS_W  = 3;
    localparam int TMO_W    = 8;
    localparam int LEVEL_W  = 16;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 24;

    // capture above this with a same-event overflow belongs to the old count
    localparam logic [CAP_W-1:0] LATE_CAPTURE_LIMIT = 16'h8000;

    // register map
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_TIMEOUT   = 3'd0,
        CFG_NUMERATOR = 3'd1,
        CFG_LVL_OFF   = 3'd2,
        CFG_LVL_RED   = 3'd3,
        CFG_LVL_YEL   = 3'd4,
        CFG_LVL_GRN   = 3'd5
    } t_cfg_idx;

    localparam logic [TMO_W-1:0]   RST_TIMEOUT   = 8'd6;
    localparam logic [SPEED_W-1:0] RST_NUMERATOR = 24'd218865;
    localparam logic [LEVEL_W-1:0] RST_LVL_OFF   = 16'd26;
    localparam logic [LEVEL_W-1:0] RST_LVL_RED   = 16'd256;
    localparam logic [LEVEL_W-1:0] RST_LVL_YEL   = 16'd768;
    localparam logic [LEVEL_W-1:0] RST_LVL_GRN   = 16'd1280;

    // color classes
    localparam logic [CLASS_W-1:0] CLS_OFF    = 3'd0;
    localparam logic [CLASS_W-1:0] CLS_RED    = 3'd1;
    localparam logic [CLASS_W-1:0] CLS_YELLOW = 3'd2;
    localparam logic [CLASS_W-1:0] CLS_GREEN  = 3'd3;
    localparam logic [CLASS_W-1:0] CLS_WHITE  = 3'd4;

    typedef struct packed {
        logic [TMO_W-1:0]   timeout;
        logic [SPEED_W-1:0] numerator;
        logic [LEVEL_W-1:0] lvl_off;
        logic [LEVEL_W-1:0] lvl_red;
        logic [LEVEL_W-1:0] lvl_yel;
        logic [LEVEL_W-1:0] lvl_grn;
    } t_cfg;

    // handshake between front/back and the period queue
    typedef struct packed {
        logic full;
        logic empty;
    } t_q_status;

endpackage

/* rtl/cpsm_in_if.sv */
// Input word channel: one timer event.
// Depends on cpsm_pkg.
interface cpsm_in_if;
    logic                     valid;
    logic                     ready;
    logic                     edge_seen;
    logic                     overflow_seen;
    logic [cpsm_pkg::CAP_W-1:0] capture_value;

    modport source (output valid, edge_seen, overflow_seen, capture_value, input ready);
    modport sink   (input valid, edge_seen, overflow_seen, capture_value, output ready);
endinterface

/* rtl/cpsm_out_if.sv */
// Output word channel: one period/speed/color report.
// Depends on cpsm_pkg.
interface cpsm_out_if;
    logic                          valid;
    logic                          ready;
    logic [cpsm_pkg::PERIOD_W-1:0] period_ticks;
    logic [cpsm_pkg::SPEED_W-1:0]  speed_fixed;
    logic [cpsm_pkg::CLASS_W-1:0]  color_class;

    modport source (output valid, period_ticks, speed_fixed, color_class, input ready);
    modport sink   (input valid, period_ticks, speed_fixed, color_class, output ready);
endinterface

/* rtl/cpsm_queue.sv */
// Short FIFO of periods between the event front end and the divider back end.
// Depends on cpsm_pkg.
module cpsm_queue #(
    parameter int DEPTH = 2
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_push,
    input  logic [cpsm_pkg::PERIOD_W-1:0] i_push_data,
    input  logic                          i_pop,
    output logic [cpsm_pkg::PERIOD_W-1:0] o_head,
    output cpsm_pkg::t_q_status           o_status
);
    import cpsm_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [PERIOD_W-1:0] r_mem [DEPTH];
    logic [PTR_W-1:0]    r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0]    r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0]    r_count, n_count;

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        ptr_inc = (p == PTR_W'(DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    assign o_status.full  = (r_count == CNT_W'(DEPTH));
    assign o_status.empty = (r_count == '0);
    assign o_head         = r_mem[r_rd_ptr];

    always_comb begin
        n_wr_ptr = i_push ? ptr_inc(r_wr_ptr) : r_wr_ptr;
        n_rd_ptr = i_pop  ? ptr_inc(r_rd_ptr) : r_rd_ptr;
        n_count  = r_count;
        if (i_push && !i_pop) begin
            n_count = r_count + 1'b1;
        end else if (i_pop && !i_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_push_data;
        end
    end

    a_no_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_push && o_status.full))
        else $error("period queue overrun");
    a_no_underrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_pop && o_status.empty))
        else $error("period queue underrun");
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(DEPTH))
        else $error("period queue count out of range");

endmodule

/* rtl/cpsm_front.sv */
// Event front end: extends captures, tracks overflows and timeout, queues periods.
// Depends on cpsm_pkg and cpsm_in_if.
module cpsm_front (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    cpsm_in_if.sink                       i_in,
    input  logic [cpsm_pkg::TMO_W-1:0]    i_timeout,
    input  cpsm_pkg::t_q_status           i_q_status,
    output logic                          o_q_push,
    output logic [cpsm_pkg::PERIOD_W-1:0] o_q_period
);
    import cpsm_pkg::*;

    logic [CAP_W-1:0]    r_ovf_cnt, n_ovf_cnt;
    logic [PERIOD_W-1:0] r_prev_cap, n_prev_cap;
    logic [TMO_W-1:0]    r_since_edge, n_since_edge;

    logic                accept;
    logic [CAP_W-1:0]    cap_hi;
    logic [PERIOD_W-1:0] ext_cap;

    // any event may report, so only take one when a queue slot is free
    assign i_in.ready = !i_q_status.full;
    assign accept     = i_in.valid && i_in.ready;

    always_comb begin
        n_ovf_cnt    = r_ovf_cnt;
        n_prev_cap   = r_prev_cap;
        n_since_edge = r_since_edge;
        o_q_push     = 1'b0;
        o_q_period   = '0;

        if (i_in.overflow_seen) begin
            n_ovf_cnt = r_ovf_cnt + 1'b1;
            if (r_since_edge != '1) begin
                n_since_edge = r_since_edge + 1'b1;
            end
        end

        // late capture: overflow in the same event happened after the edge
        cap_hi = n_ovf_cnt;
        if (i_in.overflow_seen && (i_in.capture_value > LATE_CAPTURE_LIMIT)) begin
            cap_hi = n_ovf_cnt - 1'b1;
        end
        ext_cap = {cap_hi, i_in.capture_value};

        if (i_in.edge_seen) begin
            o_q_push     = accept;
            o_q_period   = ext_cap - r_prev_cap;
            n_prev_cap   = ext_cap;
            n_since_edge = '0;
        end else if (i_in.overflow_seen && (n_since_edge > i_timeout)) begin
            o_q_push   = accept;
            o_q_period = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovf_cnt    <= '0;
            r_prev_cap   <= '0;
            r_since_edge <= '0;
        end else if (accept) begin
            r_ovf_cnt    <= n_ovf_cnt;
            r_prev_cap   <= n_prev_cap;
            r_since_edge <= n_since_edge;
        end
    end

endmodule

/* rtl/cpsm_back.sv */
// Back end: serial restoring divider for speed, color classing, output register.
// Depends on cpsm_pkg and cpsm_out_if.
module cpsm_back (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  cpsm_pkg::t_cfg                i_cfg,
    input  cpsm_pkg::t_q_status           i_q_status,
    input  logic [cpsm_pkg::PERIOD_W-1:0] i_q_head,
    output logic                          o_q_pop,
    cpsm_out_if.source                    o_out
);
    import cpsm_pkg::*;

    localparam int CNT_W = $clog2(SPEED_W);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_DIV  = 3'b010,
        S_CLS  = 3'b100
    } t_state;

    t_state              r_state, n_state;
    logic [PERIOD_W-1:0] r_div;      // divisor, also the reported period
    logic [PERIOD_W-1:0] r_rem;
    logic [SPEED_W-1:0]  r_nq;       // numerator bits out the top, quotient in
    logic [CNT_W-1:0]    r_cnt;

    logic                r_out_valid;
    logic [PERIOD_W-1:0] r_out_period;
    logic [SPEED_W-1:0]  r_out_speed;
    logic [CLASS_W-1:0]  r_out_class;

    logic [PERIOD_W:0]   rem_sh;
    logic                q_bit;
    logic [PERIOD_W:0]   rem_sub;
    logic                out_free;
    logic                load_out;
    logic [CLASS_W-1:0]  cls;

    assign rem_sh   = {r_rem, r_nq[SPEED_W-1]};
    assign q_bit    = (rem_sh >= {1'b0, r_div});
    assign rem_sub  = rem_sh - {1'b0, r_div};
    assign out_free = !r_out_valid || o_out.ready;
    assign o_q_pop  = (r_state == S_IDLE) && !i_q_status.empty;
    assign load_out = (r_state == S_CLS) && out_free;

    always_comb begin
        priority if (r_nq < SPEED_W'(i_cfg.lvl_off)) begin
            cls = CLS_OFF;
        end else if (r_nq < SPEED_W'(i_cfg.lvl_red)) begin
            cls = CLS_RED;
        end else if (r_nq < SPEED_W'(i_cfg.lvl_yel)) begin
            cls = CLS_YELLOW;
        end else if (r_nq < SPEED_W'(i_cfg.lvl_grn)) begin
            cls = CLS_GREEN;
        end else begin
            cls = CLS_WHITE;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (o_q_pop) begin
                    n_state = (i_q_head == '0) ? S_CLS : S_DIV;
                end
            end
            S_DIV: begin
                if (r_cnt == CNT_W'(SPEED_W - 1)) begin
                    n_state = S_CLS;
                end
            end
            S_CLS: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (load_out) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // datapath, no reset needed
    always_ff @(posedge i_clk) begin
        if (o_q_pop) begin
            r_div <= i_q_head;
            r_rem <= '0;
            r_cnt <= '0;
            // zero period: skip the divide, speed is zero
            r_nq  <= (i_q_head == '0) ? '0 : i_cfg.numerator;
        end else if (r_state == S_DIV) begin
            r_rem <= q_bit ? rem_sub[PERIOD_W-1:0] : rem_sh[PERIOD_W-1:0];
            r_nq  <= {r_nq[SPEED_W-2:0], q_bit};
            r_cnt <= r_cnt + 1'b1;
        end
        if (load_out) begin
            r_out_period <= r_div;
            r_out_speed  <= r_nq;   // quotient never exceeds the 24-bit field
            r_out_class  <= cls;
        end
    end

    assign o_out.valid        = r_out_valid;
    assign o_out.period_ticks = r_out_period;
    assign o_out.speed_fixed  = r_out_speed;
    assign o_out.color_class  = r_out_class;

    a_zero_period_zero_speed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        load_out && (r_div == '0) |=> (r_out_speed == '0))
        else $error("zero period reported with nonzero speed");
    a_div_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV) |-> (r_cnt < CNT_W'(SPEED_W)))
        else $error("divider ran past quotient width");
    a_pop_only_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_q_pop |=> (r_state == S_DIV || r_state == S_CLS))
        else $error("pop did not start work");

endmodule

/* rtl/capture_period_speed_meter_top.sv */
// Capture period speed meter: a timer-event front end feeding a serial
// divider back end through a short queue. Every accepted timer event updates
// the overflow count and edge timeout registers; an event with a
// rising-edge capture, or an overflow that pushes the no-edge count past
// timeout_overflows, produces one report, any other event produces none.
// A report with a nonzero period is popped, run through the one-bit-per-cycle
// restoring divide of speed_numerator by the period, then classified and
// registered once the output register is free; a zero-period report skips
// the divide. The back end takes no new period until the last is registered,
// so the divider sets the sustained rate of reports; events without reports
// go at one per cycle until the queue of Q_DEPTH periods fills. The user must
// write configuration only while the block is idle; the block does not enforce it.
// Depends on cpsm_pkg, cpsm_in_if, cpsm_out_if, cpsm_front, cpsm_queue, cpsm_back.
module capture_period_speed_meter_top #(
    parameter int Q_DEPTH = 2
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    cpsm_in_if.sink                         i_in,
    cpsm_out_if.source                      o_out,
    input  logic                            i_cfg_we,
    input  logic [cpsm_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [cpsm_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import cpsm_pkg::*;

    t_cfg                r_cfg;
    t_q_status           q_status;
    logic                q_push;
    logic                q_pop;
    logic [PERIOD_W-1:0] q_push_data;
    logic [PERIOD_W-1:0] q_head;

    // configuration registers; indexes past the map are dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.timeout   <= RST_TIMEOUT;
            r_cfg.numerator <= RST_NUMERATOR;
            r_cfg.lvl_off   <= RST_LVL_OFF;
            r_cfg.lvl_red   <= RST_LVL_RED;
            r_cfg.lvl_yel   <= RST_LVL_YEL;
            r_cfg.lvl_grn   <= RST_LVL_GRN;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_idx))
                CFG_TIMEOUT:   r_cfg.timeout   <= i_cfg_data[TMO_W-1:0];
                CFG_NUMERATOR: r_cfg.numerator <= i_cfg_data[SPEED_W-1:0];
                CFG_LVL_OFF:   r_cfg.lvl_off   <= i_cfg_data[LEVEL_W-1:0];
                CFG_LVL_RED:   r_cfg.lvl_red   <= i_cfg_data[LEVEL_W-1:0];
                CFG_LVL_YEL:   r_cfg.lvl_yel   <= i_cfg_data[LEVEL_W-1:0];
                CFG_LVL_GRN:   r_cfg.lvl_grn   <= i_cfg_data[LEVEL_W-1:0];
                default: ;
            endcase
        end
    end

    // front: event bookkeeping and period extraction
    cpsm_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in       (i_in),
        .i_timeout  (r_cfg.timeout),
        .i_q_status (q_status),
        .o_q_push   (q_push),
        .o_q_period (q_push_data)
    );

    // decouples event intake from the long divide
    cpsm_queue #(
        .DEPTH (Q_DEPTH)
    ) u_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (q_push),
        .i_push_data (q_push_data),
        .i_pop       (q_pop),
        .o_head      (q_head),
        .o_status    (q_status)
    );

    // back: speed divide, color class, output word register
    cpsm_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (r_cfg),
        .i_q_status (q_status),
        .i_q_head   (q_head),
        .o_q_pop    (q_pop),
        .o_out      (o_out)
    );

endmodule
